// ===== hw/rtl/tcgr_pkg.sv =====
// shared types, codes and font tables of the text console glyph renderer
`default_nettype none

package tcgr_pkg;

    // cursor and geometry
    localparam int COORD_BITS   = 16;
    localparam int GLYPH_COUNT  = 128;
    localparam int GLYPH_HEIGHT = 16;
    localparam int GLYPH_IDX_W  = $clog2(GLYPH_COUNT);
    localparam int ROW_IDX_W    = $clog2(GLYPH_HEIGHT);
    localparam int BITMAP_W     = GLYPH_HEIGHT * 16;
    localparam int SCREEN_W     = 13;

    localparam logic [COORD_BITS-1:0] EDGE_MARGIN = COORD_BITS'(4);
    localparam logic [COORD_BITS-1:0] LINE_STEP   = COORD_BITS'(16);

    // character codes with a special meaning
    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_RETURN  = 8'd13;

    // result kinds
    localparam logic KIND_ROW    = 1'b0;
    localparam logic KIND_SCROLL = 1'b1;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ENABLE        = 2'd0;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd1;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic newline;
        logic cret;
        logic load;
        logic wrap;
        logic scroll;
        logic emit_row;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic scroll_none;
        logic last_row;
        logic is_newline;
        logic is_return;
    } t_dp_status;

    // glyphs below space and the delete glyph are 16 pixels wide
    function automatic logic glyph_is_wide(input logic [GLYPH_IDX_W-1:0] g);
        logic w;
        w = (g < GLYPH_IDX_W'(32)) || (g == GLYPH_IDX_W'(127));
        return w;
    endfunction

    // whole glyph bitmap, first row in the top bits; narrow glyphs in the low half
    function automatic logic [BITMAP_W-1:0] glyph_bitmap(input logic [GLYPH_IDX_W-1:0] g);
        logic [BITMAP_W-1:0] b;
        case (g)
        7'd0:   b = 256'h000000000000000000004A506A505A50499E0000000000000000000000000000;
        7'd1:   b = 256'h0000000000000000000039924252325E0A527192000000000000000000000000;
        7'd2:   b = 256'h000000000000000000003BA44124311809247124000000000000000000000000;
        7'd3:   b = 256'h000000000000000000007BA44124791841247924000000000000000000000000;
        7'd4:   b = 256'h0000000000000000000079BE42487A4842487988000000000000000000000000;
        7'd5:   b = 256'h000000000000000000007A4C42527B5242D67A4E000000000000000000000000;
        7'd6:   b = 256'h0000000000000000000031A44A287A304A2849A4000000000000000000000000;
        7'd7:   b = 256'h0000000000000000000073D04A1073D04A1073DE000000000000000000000000;
        7'd8:   b = 256'h0000000000000000000078E0450078C0442079C0000000000000000000000000;
        7'd9:   b = 256'h0000000000000000000045F044407C4044404440000000000000000000000000;
        7'd10:  b = 256'h0000000000000000000041F0410041F041007D00000000000000000000000000;
        7'd11:  b = 256'h0000000000000000000045F04440444028401040000000000000000000000000;
        7'd12:  b = 256'h000000000000000000007DF041007DF041004100000000000000000000000000;
        7'd13:  b = 256'h000000000000000000003DE0411041E041203D10000000000000000000000000;
        7'd14:  b = 256'h000000000000000000003CE041103910051078E0000000000000000000000000;
        7'd15:  b = 256'h000000000000000000003DF040403840044079F0000000000000000000000000;
        7'd16:  b = 256'h0000000000000000000072384A204A384A2073B8000000000000000000000000;
        7'd17:  b = 256'h0000000000000000000071884A184A084A08719C000000000000000000000000;
        7'd18:  b = 256'h0000000000000000000071984A044A084A10719C000000000000000000000000;
        7'd19:  b = 256'h0000000000000000000071984A044A184A047198000000000000000000000000;
        7'd20:  b = 256'h0000000000000000000071844A0C4A144A1C7184000000000000000000000000;
        7'd21:  b = 256'h0000000000000000000049926A546A585BD44A52000000000000000000000000;
        7'd22:  b = 256'h000000000000000000003452429A311609127112000000000000000000000000;
        7'd23:  b = 256'h000000000000000000007BB84124793841247938000000000000000000000000;
        7'd24:  b = 256'h00000000000000000000332444B447AC44A434A4000000000000000000000000;
        7'd25:  b = 256'h000000000000000000007D1041B07D5041107D10000000000000000000000000;
        7'd26:  b = 256'h000000000000000000003A5C4252325C0A52719C000000000000000000000000;
        7'd27:  b = 256'h0000000000000000000079CE4210799040507B8E000000000000000000000000;
        7'd28:  b = 256'h0000000000000000000079C04200798040404380000000000000000000000000;
        7'd29:  b = 256'h0000000000000000000039C04200598048403B80000000000000000000000000;
        7'd30:  b = 256'h0000000000000000000071C04A00718050404B80000000000000000000000000;
        7'd31:  b = 256'h0000000000000000000049C04A00498048403380000000000000000000000000;
        7'd32:  b = 256'h00000000000000000000000000000000;
        7'd33:  b = 256'h00000000080808080808080008080000;
        7'd34:  b = 256'h00002222222200000000000000000000;
        7'd35:  b = 256'h000000001212127E24247E4848480000;
        7'd36:  b = 256'h00000000083E4948380E09493E080000;
        7'd37:  b = 256'h00000000314A4A340808162929460000;
        7'd38:  b = 256'h000000001C2222221C39454246390000;
        7'd39:  b = 256'h00000808080800000000000000000000;
        7'd40:  b = 256'h00000004080810101010101008080400;
        7'd41:  b = 256'h00000020101008080808080810102000;
        7'd42:  b = 256'h00000000000008492A1C2A4908000000;
        7'd43:  b = 256'h0000000000000808087F080808000000;
        7'd44:  b = 256'h00000000000000000000000018080810;
        7'd45:  b = 256'h0000000000000000007E000000000000;
        7'd46:  b = 256'h00000000000000000000000018180000;
        7'd47:  b = 256'h00000000020204080810102040400000;
        7'd48:  b = 256'h00000000182442424242424224180000;
        7'd49:  b = 256'h000000000818280808080808083E0000;
        7'd50:  b = 256'h000000003C4242020C102040407E0000;
        7'd51:  b = 256'h000000003C4242021C020242423C0000;
        7'd52:  b = 256'h00000000040C142444447E0404040000;
        7'd53:  b = 256'h000000007E4040407C020202423C0000;
        7'd54:  b = 256'h000000001C2040407C424242423C0000;
        7'd55:  b = 256'h000000007E0202040404080808080000;
        7'd56:  b = 256'h000000003C4242423C424242423C0000;
        7'd57:  b = 256'h000000003C4242423E02020204380000;
        7'd58:  b = 256'h00000000000018180000001818000000;
        7'd59:  b = 256'h00000000000018180000001808081000;
        7'd60:  b = 256'h00000000000204081020100804020000;
        7'd61:  b = 256'h000000000000007E0000007E00000000;
        7'd62:  b = 256'h00000000004020100804081020400000;
        7'd63:  b = 256'h000000003C4242020408080008080000;
        7'd64:  b = 256'h000000001C224A565252524E201E0000;
        7'd65:  b = 256'h0000000018242442427E424242420000;
        7'd66:  b = 256'h000000007C4242427C424242427C0000;
        7'd67:  b = 256'h000000003C42424040404042423C0000;
        7'd68:  b = 256'h00000000784442424242424244780000;
        7'd69:  b = 256'h000000007E4040407C404040407E0000;
        7'd70:  b = 256'h000000007E4040407C40404040400000;
        7'd71:  b = 256'h000000003C424240404E4242463A0000;
        7'd72:  b = 256'h00000000424242427E42424242420000;
        7'd73:  b = 256'h000000003E08080808080808083E0000;
        7'd74:  b = 256'h000000001F0404040404044444380000;
        7'd75:  b = 256'h00000000424448506060504844420000;
        7'd76:  b = 256'h000000004040404040404040407E0000;
        7'd77:  b = 256'h00000000424266665A5A424242420000;
        7'd78:  b = 256'h0000000042626252524A4A4646420000;
        7'd79:  b = 256'h000000003C42424242424242423C0000;
        7'd80:  b = 256'h000000007C4242427C40404040400000;
        7'd81:  b = 256'h000000003C4242424242425A663C0300;
        7'd82:  b = 256'h000000007C4242427C48444442420000;
        7'd83:  b = 256'h000000003C424240300C0242423C0000;
        7'd84:  b = 256'h000000007F0808080808080808080000;
        7'd85:  b = 256'h000000004242424242424242423C0000;
        7'd86:  b = 256'h00000000414141222222141408080000;
        7'd87:  b = 256'h00000000424242425A5A666642420000;
        7'd88:  b = 256'h00000000424224241818242442420000;
        7'd89:  b = 256'h00000000414122221408080808080000;
        7'd90:  b = 256'h000000007E02020408102040407E0000;
        7'd91:  b = 256'h0000000E080808080808080808080E00;
        7'd92:  b = 256'h00000000404020101008080402020000;
        7'd93:  b = 256'h00000070101010101010101010107000;
        7'd94:  b = 256'h00001824420000000000000000000000;
        7'd95:  b = 256'h00000000000000000000000000007F00;
        7'd96:  b = 256'h00201008000000000000000000000000;
        7'd97:  b = 256'h0000000000003C42023E4242463A0000;
        7'd98:  b = 256'h0000004040405C6242424242625C0000;
        7'd99:  b = 256'h0000000000003C4240404040423C0000;
        7'd100: b = 256'h0000000202023A4642424242463A0000;
        7'd101: b = 256'h0000000000003C42427E4040423C0000;
        7'd102: b = 256'h0000000C1010107C1010101010100000;
        7'd103: b = 256'h0000000000023A44444438203C42423C;
        7'd104: b = 256'h0000004040405C624242424242420000;
        7'd105: b = 256'h000000080800180808080808083E0000;
        7'd106: b = 256'h0000000404000C040404040404044830;
        7'd107: b = 256'h00000000404044485060504844420000;
        7'd108: b = 256'h000000001808080808080808083E0000;
        7'd109: b = 256'h00000000000076494949494949490000;
        7'd110: b = 256'h0000000000005C624242424242420000;
        7'd111: b = 256'h0000000000003C4242424242423C0000;
        7'd112: b = 256'h0000000000005C6242424242625C4040;
        7'd113: b = 256'h0000000000003A4642424242463A0202;
        7'd114: b = 256'h0000000000005C624240404040400000;
        7'd115: b = 256'h0000000000003C4240300C02423C0000;
        7'd116: b = 256'h0000000010107C1010101010100C0000;
        7'd117: b = 256'h000000000000424242424242463A0000;
        7'd118: b = 256'h00000000000042424224242418180000;
        7'd119: b = 256'h00000000000041494949494949360000;
        7'd120: b = 256'h00000000000042422418182442420000;
        7'd121: b = 256'h0000000000004242424242261A02023C;
        7'd122: b = 256'h0000000000007E0204081020407E0000;
        7'd123: b = 256'h0000000C101008081010080810100C00;
        7'd124: b = 256'h00000808080808080808080808080808;
        7'd125: b = 256'h00000030080810100808101008083000;
        7'd126: b = 256'h00000031494600000000000000000000;
        7'd127: b = 256'h0000000000000000000073D04A104BD04A1073DE000000000000000000000000;
        default: b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/text_console_glyph_renderer.sv =====
// top level of the text console glyph renderer with its register port
`default_nettype none

// Text console glyph renderer. Each transaction on the input channel is one
// character code; newline and carriage return move the pixel cursor and give
// no result, any other code draws the glyph picked by its low 7 bits from the
// built-in 128 glyph font (8 or 16 pixels wide, 16 rows). A drawn character
// gives an optional scroll result followed by 16 row results, the last one
// flagged. Nothing is processed while the enable register is 0. Newline and
// carriage return never make the block busy. A printable character occupies
// the block through these steps: latch the glyph, the right border check, the
// bottom border check (which emits the scroll result), then one row a cycle
// from the latched glyph through the single output register, while the output
// is not stalled. Registers on the APB port: enable at 0x0, screen width at
// 0x4, screen height at 0x8.
module text_console_glyph_renderer
    import tcgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_code,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic [12:0]      o_scroll_lines,
    output logic [15:0]      o_pixel_x,
    output logic [15:0]      o_pixel_y,
    output logic [4:0]       o_row_width,
    output logic [15:0]      o_row_bits,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic                r_enable;
    logic [SCREEN_W-1:0] r_screen_width;
    logic [SCREEN_W-1:0] r_screen_height;
    logic                cfg_write;
    logic [1:0]          reg_idx;
    t_dp_cmd             cmd;
    t_dp_status          status;

    // register port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable        <= 1'b0;
            r_screen_width  <= SCREEN_W'(1024);
            r_screen_height <= SCREEN_W'(768);
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_ENABLE:        r_enable        <= pwdata[0];
                REG_SCREEN_WIDTH:  r_screen_width  <= pwdata[SCREEN_W-1:0];
                REG_SCREEN_HEIGHT: r_screen_height <= pwdata[SCREEN_W-1:0];
                default: ;
            endcase
        end
    end

    // register read
    always_comb begin
        unique case (reg_idx)
            REG_ENABLE:        prdata = {31'd0, r_enable};
            REG_SCREEN_WIDTH:  prdata = 32'(r_screen_width);
            REG_SCREEN_HEIGHT: prdata = 32'(r_screen_height);
            default:           prdata = '0;
        endcase
    end

    // sequencing
    tcgr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_enable (r_enable),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    // cursor, glyph and output
    tcgr_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_char_code     (i_char_code),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_scroll_lines  (o_scroll_lines),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_row_width     (o_row_width),
        .o_row_bits      (o_row_bits),
        .o_last          (o_last)
    );

    // a scroll never carries a zero count
    a_scroll_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_SCROLL)) |-> (o_scroll_lines != 13'd0))
        else $error("scroll transaction with zero count");

    // only a row closes a character
    a_last_is_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_kind == KIND_ROW))
        else $error("last flag on a scroll transaction");

    // row width is one of the two glyph widths
    a_row_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_ROW)) |-> ((o_row_width == 5'd8) || (o_row_width == 5'd16)))
        else $error("bad row width");

    // a printable character keeps the block busy
    a_busy_after_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && r_enable && (i_char_code != CHAR_NEWLINE)
         && (i_char_code != CHAR_RETURN)) |=> o_stall)
        else $error("block not busy after a printable character");

endmodule

`default_nettype wire

// ===== hw/rtl/tcgr_ctrl.sv =====
// controller state machine sequencing one character through the datapath
`default_nettype none

module tcgr_ctrl
    import tcgr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic       i_enable,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_stall
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WRAP   = 2'd1;
    localparam logic [1:0] ST_SCROLL = 2'd2;
    localparam logic [1:0] ST_ROWS   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // input is taken only between characters
    assign o_stall = (r_state != ST_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && i_enable) begin
                    if (i_status.is_newline) begin
                        o_cmd.newline = 1'b1;
                    end else if (i_status.is_return) begin
                        o_cmd.cret = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_WRAP;
                    end
                end
            end
            ST_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = ST_SCROLL;
            end
            ST_SCROLL: begin
                if (i_status.scroll_none) begin
                    n_state = ST_ROWS;
                end else if (i_status.out_free) begin
                    o_cmd.scroll = 1'b1;
                    n_state      = ST_ROWS;
                end
            end
            ST_ROWS: begin
                if (i_status.out_free) begin
                    o_cmd.emit_row = 1'b1;
                    if (i_status.last_row) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tcgr_datapath.sv =====
// cursor, glyph register, scroll arithmetic and output register
`default_nettype none

module tcgr_datapath
    import tcgr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    input  wire logic [7:0]            i_char_code,
    input  wire logic [SCREEN_W-1:0]   i_screen_width,
    input  wire logic [SCREEN_W-1:0]   i_screen_height,
    input  wire logic                  i_stall,
    output logic                       o_valid,
    output logic                       o_kind,
    output logic [12:0]                o_scroll_lines,
    output logic [15:0]                o_pixel_x,
    output logic [15:0]                o_pixel_y,
    output logic [4:0]                 o_row_width,
    output logic [15:0]                o_row_bits,
    output logic                       o_last
);

    logic [COORD_BITS-1:0] r_col;
    logic [COORD_BITS-1:0] r_row;
    logic [COORD_BITS-1:0] n_col;
    logic [COORD_BITS-1:0] n_row;
    logic [BITMAP_W-1:0]   r_bitmap;
    logic                  r_wide;
    logic [ROW_IDX_W-1:0]  r_line;
    logic                  r_out_valid;

    logic [GLYPH_IDX_W-1:0] glyph;
    logic                   glyph_wide;
    logic [BITMAP_W-1:0]    glyph_bits;
    logic [COORD_BITS-1:0]  width;
    logic [COORD_BITS:0]    right_edge;
    logic [COORD_BITS:0]    bottom_edge;
    logic                   over_bottom;
    logic [COORD_BITS:0]    excess_up;
    logic [12:0]            steps_raw;
    logic [12:0]            steps_cap;
    logic [12:0]            steps;
    logic                   out_free;

    // glyph lookup from the font table
    assign glyph      = i_char_code[GLYPH_IDX_W-1:0];
    assign glyph_wide = glyph_is_wide(glyph);
    assign glyph_bits = glyph_bitmap(glyph);
    assign width      = r_wide ? COORD_BITS'(16) : COORD_BITS'(8);

    // right border test
    assign right_edge = {1'b0, r_col} + {1'b0, width} + {1'b0, EDGE_MARGIN};

    // bottom border: rows to scroll, rounded up and capped by the cursor row
    assign bottom_edge = {1'b0, r_row} + (COORD_BITS+1)'(GLYPH_HEIGHT + 4);
    assign over_bottom = bottom_edge > (COORD_BITS+1)'(i_screen_height);
    assign excess_up   = bottom_edge - (COORD_BITS+1)'(i_screen_height)
                         + (COORD_BITS+1)'(15);
    assign steps_raw   = 13'(excess_up >> 4);
    assign steps_cap   = 13'(r_row >> 4);
    assign steps       = (steps_raw > steps_cap) ? steps_cap : steps_raw;

    // output register can take a new transaction
    assign out_free = !r_out_valid || !i_stall;

    assign o_status.out_free    = out_free;
    assign o_status.scroll_none = !over_bottom || (steps == 13'd0);
    assign o_status.last_row    = (r_line == ROW_IDX_W'(GLYPH_HEIGHT - 1));
    assign o_status.is_newline  = (i_char_code == CHAR_NEWLINE);
    assign o_status.is_return   = (i_char_code == CHAR_RETURN);

    // cursor next value
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.newline) begin
            n_col = EDGE_MARGIN;
            n_row = r_row + LINE_STEP;
        end
        if (i_cmd.cret) begin
            n_col = EDGE_MARGIN;
        end
        if (i_cmd.wrap && (right_edge > (COORD_BITS+1)'(i_screen_width))) begin
            n_col = '0;
            n_row = r_row + LINE_STEP;
        end
        if (i_cmd.scroll) begin
            n_row = r_row - {steps[COORD_BITS-5:0], 4'b0000};
        end
        if (i_cmd.emit_row && o_status.last_row) begin
            n_col = r_col + width;
        end
    end

    // cursor registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= EDGE_MARGIN;
            r_row <= EDGE_MARGIN;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // glyph register, shifted one row per emitted row
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_wide   <= glyph_wide;
            r_line   <= '0;
            r_bitmap <= glyph_wide ? glyph_bits
                                   : {glyph_bits[BITMAP_W/2-1:0], {(BITMAP_W/2){1'b0}}};
        end else if (i_cmd.emit_row) begin
            r_line   <= r_line + ROW_IDX_W'(1);
            r_bitmap <= r_wide ? {r_bitmap[BITMAP_W-17:0], 16'h0000}
                               : {r_bitmap[BITMAP_W-9:0], 8'h00};
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.scroll || i_cmd.emit_row) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scroll) begin
            o_kind         <= KIND_SCROLL;
            o_scroll_lines <= steps;
            o_pixel_x      <= '0;
            o_pixel_y      <= '0;
            o_row_width    <= '0;
            o_row_bits     <= '0;
            o_last         <= 1'b0;
        end else if (i_cmd.emit_row) begin
            o_kind         <= KIND_ROW;
            o_scroll_lines <= '0;
            o_pixel_x      <= 16'(r_col);
            o_pixel_y      <= 16'(r_row + COORD_BITS'(r_line));
            o_row_width    <= r_wide ? 5'd16 : 5'd8;
            o_row_bits     <= r_wide ? r_bitmap[BITMAP_W-1 -: 16]
                                     : {8'h00, r_bitmap[BITMAP_W-1 -: 8]};
            o_last         <= o_status.last_row;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire
